>>> design/morse_character_keyer_unit_defines.svh
// Assertion macros for the morse character keyer.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MCK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCK_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> design/mck_pkg.sv
// Package for the morse character keyer: widths, register indexes,
// command and segment types, and the fixed Morse pattern table. No dependencies.
package mck_pkg;

    localparam int CHAR_W  = 8;
    localparam int TICK_W  = 31;
    localparam int LAMP_W  = 2;
    localparam int IDX_W   = 3;
    localparam int ELEM_W  = 6;
    localparam int COUNT_W = 3;
    localparam int TABLE_STORED = 48;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [IDX_W-1:0] REG_DOT       = 3'd0;
    localparam logic [IDX_W-1:0] REG_DASH      = 3'd1;
    localparam logic [IDX_W-1:0] REG_ELEM_GAP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_CHAR_GAP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_WORD_GAP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LAMP_MASK = 3'd5;

    typedef struct packed {
        logic [CHAR_W-1:0]  code;
        logic [7:0]         bits;
        logic [COUNT_W-1:0] count;
    } t_pattern;

    typedef struct packed {
        logic               is_space;
        logic [ELEM_W-1:0]  bits;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic [TICK_W-1:0] dot_ticks;
        logic [TICK_W-1:0] dash_ticks;
        logic [TICK_W-1:0] element_gap_ticks;
        logic [TICK_W-1:0] char_gap_ticks;
        logic [TICK_W-1:0] word_gap_ticks;
        logic [LAMP_W-1:0] lamp_mask;
    } t_cfg;

    typedef struct packed {
        logic              key_down;
        logic [LAMP_W-1:0] lamp_select;
        logic [TICK_W-1:0] duration;
        logic              last;
    } t_seg;

    typedef struct packed {
        logic hit;
        t_cmd cmd;
    } t_hit;

    // bits: elements left-aligned, 1 = dash
    localparam t_pattern PATTERNS [TABLE_STORED] = '{
        '{8'h41, 8'h40, 3'd2}, '{8'h42, 8'h80, 3'd4}, '{8'h43, 8'hA0, 3'd4},
        '{8'h44, 8'h80, 3'd3}, '{8'h45, 8'h00, 3'd1}, '{8'h46, 8'h20, 3'd4},
        '{8'h47, 8'hC0, 3'd3}, '{8'h48, 8'h00, 3'd4}, '{8'h49, 8'h00, 3'd2},
        '{8'h4A, 8'h70, 3'd4}, '{8'h4B, 8'hA0, 3'd3}, '{8'h4C, 8'h40, 3'd4},
        '{8'h4D, 8'hC0, 3'd2}, '{8'h4E, 8'h80, 3'd2}, '{8'h4F, 8'hE0, 3'd3},
        '{8'h50, 8'h60, 3'd4}, '{8'h51, 8'hD0, 3'd4}, '{8'h52, 8'h40, 3'd3},
        '{8'h53, 8'h00, 3'd3}, '{8'h54, 8'h80, 3'd1}, '{8'h55, 8'h20, 3'd3},
        '{8'h56, 8'h10, 3'd4}, '{8'h57, 8'h60, 3'd3}, '{8'h58, 8'h90, 3'd4},
        '{8'h59, 8'hB0, 3'd4}, '{8'h5A, 8'hC0, 3'd4}, '{8'h30, 8'hF8, 3'd5},
        '{8'h31, 8'h78, 3'd5}, '{8'h32, 8'h38, 3'd5}, '{8'h33, 8'h18, 3'd5},
        '{8'h34, 8'h08, 3'd5}, '{8'h35, 8'h00, 3'd5}, '{8'h36, 8'h80, 3'd5},
        '{8'h37, 8'hC0, 3'd5}, '{8'h38, 8'hE0, 3'd5}, '{8'h39, 8'hF0, 3'd5},
        '{8'h2E, 8'h54, 3'd6}, '{8'h2C, 8'hCC, 3'd6}, '{8'h3F, 8'h30, 3'd6},
        '{8'h2D, 8'h84, 3'd6}, '{8'h40, 8'h68, 3'd6}, '{8'h5F, 8'h34, 3'd6},
        '{8'h2B, 8'h50, 3'd5}, '{8'h3B, 8'hA8, 3'd6}, '{8'h26, 8'h40, 3'd5},
        '{8'h2F, 8'h90, 3'd5}, '{8'h28, 8'hB0, 3'd5}, '{8'h29, 8'hB4, 3'd6}
    };

    function automatic t_hit f_lookup(input logic [CHAR_W-1:0] ch, input int limit);
        t_hit res;
        res = '0;
        if (ch == CHAR_SPACE) begin
            res.hit          = 1'b1;
            res.cmd.is_space = 1'b1;
        end else begin
            for (int i = 0; i < TABLE_STORED; i++) begin
                if (i < limit && PATTERNS[i].code == ch) begin
                    res.hit       = 1'b1;
                    res.cmd.bits  = PATTERNS[i].bits[7:2];
                    res.cmd.count = PATTERNS[i].count;
                end
            end
        end
        return res;
    endfunction

endpackage

>>> design/mck_char_if.sv
// Character input channel: valid/ready handshake with one ASCII code.
// Depends on mck_pkg.
interface mck_char_if;
    logic                       valid;
    logic                       ready;
    logic [mck_pkg::CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

>>> design/mck_seg_if.sv
// Keying segment output channel: valid/ready handshake with one segment.
// Depends on mck_pkg.
interface mck_seg_if;
    logic                       valid;
    logic                       ready;
    logic                       key_down;
    logic [mck_pkg::LAMP_W-1:0] lamp_select;
    logic [mck_pkg::TICK_W-1:0] duration;
    logic                       last;

    modport source (output valid, output key_down, output lamp_select,
                    output duration, output last, input ready);
    modport sink   (input valid, input key_down, input lamp_select,
                    input duration, input last, output ready);
endinterface

>>> design/mck_front.sv
// Front end: accepts characters, classifies them via the pattern table
// and pushes known ones as commands. Depends on mck_pkg, mck_char_if.
module mck_front #(
    parameter int TABLE_ENTRIES = 48
) (
    mck_char_if.sink      i_char,
    input  logic          i_push_ready,
    output logic          o_push,
    output mck_pkg::t_cmd o_cmd
);
    localparam int LIMIT = (TABLE_ENTRIES < mck_pkg::TABLE_STORED) ?
                           TABLE_ENTRIES : mck_pkg::TABLE_STORED;

    mck_pkg::t_hit w_hit;

    always_comb begin
        w_hit = mck_pkg::f_lookup(i_char.character, LIMIT);
    end

    // unknown codes are taken and dropped
    assign i_char.ready = i_push_ready;
    assign o_push       = i_char.valid && i_push_ready && w_hit.hit;
    assign o_cmd        = w_hit.cmd;
endmodule

>>> design/mck_queue.sv
// Two-entry command queue between front and back end.
// Depends on mck_pkg.
module mck_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mck_pkg::t_cmd i_cmd,
    output logic          o_push_ready,
    output logic          o_valid,
    output mck_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    mck_pkg::t_cmd r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

>>> design/mck_back.sv
// Back end: sequences one command into keying segments, one per cycle unless the sink
// stalls, via an output register. Depends on mck_pkg, mck_seg_if, the defines header.
`include "morse_character_keyer_unit_defines.svh"
module mck_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mck_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  mck_pkg::t_cmd i_cmd,
    output logic          o_pop,
    mck_seg_if.source     o_seg
);
    logic                                r_busy;
    logic                                r_space;
    logic                                r_gap;
    logic [mck_pkg::ELEM_W-1:0]          r_bits;
    logic [mck_pkg::COUNT_W-1:0]         r_left;
    logic                                r_out_valid;
    mck_pkg::t_seg                       r_out;

    logic          w_load;
    logic          w_emit;
    logic          w_pop;
    mck_pkg::t_seg w_seg;

    assign w_load = !r_out_valid || o_seg.ready;
    assign w_emit = r_busy && w_load;
    assign w_pop  = !r_busy && i_cmd_valid;
    assign o_pop  = w_pop;

    always_comb begin
        w_seg             = '0;
        w_seg.lamp_select = i_cfg.lamp_mask;
        if (r_space) begin
            w_seg.duration = i_cfg.word_gap_ticks;
            w_seg.last     = 1'b1;
        end else if (r_left == '0) begin
            w_seg.duration = i_cfg.char_gap_ticks;
            w_seg.last     = 1'b1;
        end else if (!r_gap) begin
            w_seg.key_down = 1'b1;
            w_seg.duration = r_bits[mck_pkg::ELEM_W-1] ? i_cfg.dash_ticks : i_cfg.dot_ticks;
        end else begin
            w_seg.duration = i_cfg.element_gap_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_gap       <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_busy  <= 1'b1;
                r_space <= i_cmd.is_space;
                r_bits  <= i_cmd.bits;
                r_left  <= i_cmd.count;
                r_gap   <= 1'b0;
            end else if (w_emit) begin
                if (w_seg.last) begin
                    r_busy <= 1'b0;
                end else if (!r_gap) begin
                    r_gap <= 1'b1;
                end else begin
                    r_gap  <= 1'b0;
                    r_bits <= {r_bits[mck_pkg::ELEM_W-2:0], 1'b0};
                    r_left <= r_left - 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_seg;
        end
    end

    assign o_seg.valid       = r_out_valid;
    assign o_seg.key_down    = r_out.key_down;
    assign o_seg.lamp_select = r_out.lamp_select;
    assign o_seg.duration    = r_out.duration;
    assign o_seg.last        = r_out.last;

    `MCK_ASSERT(a_left_range, i_clk, i_rst_n, r_left <= 3'd6, "element count above six")
    `MCK_ASSERT(a_pop_starts, i_clk, i_rst_n, w_pop |=> r_busy, "pop did not start a command")
    `MCK_ASSERT(a_char_end, i_clk, i_rst_n, (w_emit && w_seg.last) |=> (!r_busy && r_out_valid && o_seg.last), "final segment not presented")
    `MCK_ASSERT_NEVER(a_mark_last, i_clk, i_rst_n, r_out_valid && r_out.key_down && r_out.last, "mark segment flagged last")
endmodule

>>> design/morse_character_keyer_unit.sv
// Morse character keyer top level: configuration registers, front end,
// command queue and segment sequencer. Depends on mck_pkg, mck_char_if, mck_seg_if,
// mck_front, mck_queue, mck_back.
//
// Each character item becomes a run of keying segments. A space gives one
// word-gap segment; a table character with n elements gives 2n+1 segments
// (mark and element gap per element, then a character gap); any other code
// is taken and gives nothing. The segment sequencer emits one segment per
// cycle while the sink accepts them, and it loads the next command only
// once the last segment of the previous one has been emitted. A two-entry
// queue lets the front accept further characters meanwhile; the output
// register holds a segment while the sink stalls. Configuration is written
// through i_cfg_we/i_cfg_index/i_cfg_data; unknown indexes are ignored.
module morse_character_keyer_unit #(
    parameter int TABLE_ENTRIES = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mck_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [mck_pkg::TICK_W-1:0] i_cfg_data,
    mck_char_if.sink                   i_char,
    mck_seg_if.source                  o_seg
);
    mck_pkg::t_cfg r_cfg;
    mck_pkg::t_cmd w_push_cmd;
    mck_pkg::t_cmd w_pop_cmd;
    logic          w_push;
    logic          w_push_ready;
    logic          w_cmd_valid;
    logic          w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_ticks         <= 31'd2666666;
            r_cfg.dash_ticks        <= 31'd10666664;
            r_cfg.element_gap_ticks <= 31'd3466665;
            r_cfg.char_gap_ticks    <= 31'd13866663;
            r_cfg.word_gap_ticks    <= 31'd41599989;
            r_cfg.lamp_mask         <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mck_pkg::REG_DOT:       r_cfg.dot_ticks         <= i_cfg_data;
                mck_pkg::REG_DASH:      r_cfg.dash_ticks        <= i_cfg_data;
                mck_pkg::REG_ELEM_GAP:  r_cfg.element_gap_ticks <= i_cfg_data;
                mck_pkg::REG_CHAR_GAP:  r_cfg.char_gap_ticks    <= i_cfg_data;
                mck_pkg::REG_WORD_GAP:  r_cfg.word_gap_ticks    <= i_cfg_data;
                mck_pkg::REG_LAMP_MASK: r_cfg.lamp_mask <= i_cfg_data[mck_pkg::LAMP_W-1:0];
                default: ;
            endcase
        end
    end

    mck_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .i_char       (i_char),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    mck_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_valid      (w_cmd_valid),
        .o_cmd        (w_pop_cmd),
        .i_pop        (w_pop)
    );

    mck_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_pop_cmd),
        .o_pop       (w_pop),
        .o_seg       (o_seg)
    );
endmodule

>>> dv/morse_character_keyer_unit_tb.sv
// Self-checking testbench for morse_character_keyer_unit: drives characters, predicts
// each keying segment from its own Morse table and compares every output item in order.
// Depends on mck_pkg, mck_char_if, mck_seg_if and the keyer RTL.
module morse_character_keyer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASES       = 6;

    localparam logic [mck_pkg::IDX_W-1:0]  REG_SPARE_LO = 3'd6;
    localparam logic [mck_pkg::IDX_W-1:0]  REG_SPARE_HI = 3'd7;
    localparam logic [mck_pkg::TICK_W-1:0] TICKS_MAX    = '1;

    typedef struct packed {
        logic [mck_pkg::TICK_W-1:0] dot;
        logic [mck_pkg::TICK_W-1:0] dash;
        logic [mck_pkg::TICK_W-1:0] elem_gap;
        logic [mck_pkg::TICK_W-1:0] char_gap;
        logic [mck_pkg::TICK_W-1:0] word_gap;
        logic [mck_pkg::LAMP_W-1:0] lamp;
    } t_keyer_regs;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [mck_pkg::IDX_W-1:0]  i_cfg_index;
    logic [mck_pkg::TICK_W-1:0] i_cfg_data;

    mck_char_if chr_if ();
    mck_seg_if  seg_if ();

    t_keyer_regs                regs;
    logic [mck_pkg::CHAR_W-1:0] chars_to_send [$];
    mck_pkg::t_seg              segs_due [$];
    int                         src_idle_pct;
    int                         sink_idle_pct;
    int                         mismatch_count = 0;
    int                         quiet_cycles = 0;
    string sendable   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?-@_+;&/()";
    string directed_a = "ET05-)@";
    string directed_b = "AZ9/_;&,?";

    morse_character_keyer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (chr_if),
        .o_seg       (seg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // {element count, elements left-aligned with 1 = dash}; count 0 = not sendable
    function automatic logic [10:0] morse_of(input logic [mck_pkg::CHAR_W-1:0] ch);
        case (ch)
            "A": return {3'd2, 8'h40};  "B": return {3'd4, 8'h80};
            "C": return {3'd4, 8'hA0};  "D": return {3'd3, 8'h80};
            "E": return {3'd1, 8'h00};  "F": return {3'd4, 8'h20};
            "G": return {3'd3, 8'hC0};  "H": return {3'd4, 8'h00};
            "I": return {3'd2, 8'h00};  "J": return {3'd4, 8'h70};
            "K": return {3'd3, 8'hA0};  "L": return {3'd4, 8'h40};
            "M": return {3'd2, 8'hC0};  "N": return {3'd2, 8'h80};
            "O": return {3'd3, 8'hE0};  "P": return {3'd4, 8'h60};
            "Q": return {3'd4, 8'hD0};  "R": return {3'd3, 8'h40};
            "S": return {3'd3, 8'h00};  "T": return {3'd1, 8'h80};
            "U": return {3'd3, 8'h20};  "V": return {3'd4, 8'h10};
            "W": return {3'd3, 8'h60};  "X": return {3'd4, 8'h90};
            "Y": return {3'd4, 8'hB0};  "Z": return {3'd4, 8'hC0};
            "0": return {3'd5, 8'hF8};  "1": return {3'd5, 8'h78};
            "2": return {3'd5, 8'h38};  "3": return {3'd5, 8'h18};
            "4": return {3'd5, 8'h08};  "5": return {3'd5, 8'h00};
            "6": return {3'd5, 8'h80};  "7": return {3'd5, 8'hC0};
            "8": return {3'd5, 8'hE0};  "9": return {3'd5, 8'hF0};
            ".": return {3'd6, 8'h54};  ",": return {3'd6, 8'hCC};
            "?": return {3'd6, 8'h30};  "-": return {3'd6, 8'h84};
            "@": return {3'd6, 8'h68};  "_": return {3'd6, 8'h34};
            "+": return {3'd5, 8'h50};  ";": return {3'd6, 8'hA8};
            "&": return {3'd5, 8'h40};  "/": return {3'd5, 8'h90};
            "(": return {3'd5, 8'hB0};  ")": return {3'd6, 8'hB4};
            default: return '0;
        endcase
    endfunction

    function automatic mck_pkg::t_seg seg_of(input logic down,
                                             input logic [mck_pkg::TICK_W-1:0] ticks,
                                             input logic fin);
        mck_pkg::t_seg s;
        s.key_down    = down;
        s.lamp_select = regs.lamp;
        s.duration    = ticks;
        s.last        = fin;
        return s;
    endfunction

    function automatic void expand_character(input logic [mck_pkg::CHAR_W-1:0] ch);
        logic [10:0] pat;
        logic [7:0]  elems;
        int          n;
        if (ch == mck_pkg::CHAR_SPACE) begin
            segs_due.push_back(seg_of(1'b0, regs.word_gap, 1'b1));
            return;
        end
        pat   = morse_of(ch);
        n     = int'(pat[10:8]);
        elems = pat[7:0];
        for (int e = 0; e < n; e++) begin
            segs_due.push_back(seg_of(1'b1, elems[7] ? regs.dash : regs.dot, 1'b0));
            segs_due.push_back(seg_of(1'b0, regs.elem_gap, 1'b0));
            elems = elems << 1;
        end
        if (n > 0)
            segs_due.push_back(seg_of(1'b0, regs.char_gap, 1'b1));
    endfunction

    function automatic logic [mck_pkg::CHAR_W-1:0] random_character();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return sendable[$urandom_range(0, 47)];
        else if (r < 82)
            return mck_pkg::CHAR_SPACE;
        return mck_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [mck_pkg::IDX_W-1:0] idx,
                             input logic [mck_pkg::TICK_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            mck_pkg::REG_DOT:       regs.dot      = data;
            mck_pkg::REG_DASH:      regs.dash     = data;
            mck_pkg::REG_ELEM_GAP:  regs.elem_gap = data;
            mck_pkg::REG_CHAR_GAP:  regs.char_gap = data;
            mck_pkg::REG_WORD_GAP:  regs.word_gap = data;
            mck_pkg::REG_LAMP_MASK: regs.lamp     = data[mck_pkg::LAMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int phase);
        case (phase)
            1: begin
                write_reg(mck_pkg::REG_DOT, 31'd1);
                write_reg(mck_pkg::REG_DASH, 31'd1);
                write_reg(mck_pkg::REG_ELEM_GAP, '0);
                write_reg(mck_pkg::REG_CHAR_GAP, '0);
                write_reg(mck_pkg::REG_WORD_GAP, '0);
                write_reg(mck_pkg::REG_LAMP_MASK, '0);
                write_reg(REG_SPARE_LO, mck_pkg::TICK_W'($urandom()));
                write_reg(REG_SPARE_HI, mck_pkg::TICK_W'($urandom()));
            end
            2: begin
                write_reg(mck_pkg::REG_DOT, TICKS_MAX);
                write_reg(mck_pkg::REG_DASH, TICKS_MAX);
                write_reg(mck_pkg::REG_ELEM_GAP, TICKS_MAX);
                write_reg(mck_pkg::REG_CHAR_GAP, TICKS_MAX);
                write_reg(mck_pkg::REG_WORD_GAP, TICKS_MAX);
                write_reg(mck_pkg::REG_LAMP_MASK, TICKS_MAX);
            end
            5: begin
                write_reg(mck_pkg::REG_DOT, mck_pkg::TICK_W'($urandom_range(1, 16)));
                write_reg(mck_pkg::REG_DASH, mck_pkg::TICK_W'($urandom_range(1, 16)));
                write_reg(mck_pkg::REG_ELEM_GAP, mck_pkg::TICK_W'($urandom_range(0, 16)));
                write_reg(mck_pkg::REG_CHAR_GAP, mck_pkg::TICK_W'($urandom_range(0, 16)));
                write_reg(mck_pkg::REG_WORD_GAP, mck_pkg::TICK_W'($urandom_range(0, 16)));
                write_reg(mck_pkg::REG_LAMP_MASK, mck_pkg::TICK_W'($urandom()));
            end
            default: begin
                write_reg(mck_pkg::REG_DOT,
                          mck_pkg::TICK_W'($urandom_range(1, 32'h7FFF_FFFF)));
                write_reg(mck_pkg::REG_DASH,
                          mck_pkg::TICK_W'($urandom_range(1, 32'h7FFF_FFFF)));
                write_reg(mck_pkg::REG_ELEM_GAP,
                          mck_pkg::TICK_W'($urandom_range(0, 32'h7FFF_FFFF)));
                write_reg(mck_pkg::REG_CHAR_GAP,
                          mck_pkg::TICK_W'($urandom_range(0, 32'h7FFF_FFFF)));
                write_reg(mck_pkg::REG_WORD_GAP,
                          mck_pkg::TICK_W'($urandom_range(0, 32'h7FFF_FFFF)));
                write_reg(mck_pkg::REG_LAMP_MASK, (phase == 3) ? 31'd1 : 31'd2);
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // unknown codes give no segment, so allow the back end time to finish them
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (chars_to_send.size() != 0 || chr_if.valid || segs_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chr_if.valid <= 1'b0;
        end else begin
            if (chr_if.valid && chr_if.ready)
                expand_character(chr_if.character);
            if (!chr_if.valid || chr_if.ready) begin
                if (chars_to_send.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    chr_if.valid     <= 1'b1;
                    chr_if.character <= chars_to_send.pop_front();
                end else begin
                    chr_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : seg_monitor
        mck_pkg::t_seg want;
        if (!i_rst_n) begin
            seg_if.ready <= 1'b0;
        end else begin
            if (seg_if.valid && seg_if.ready) begin
                if (segs_due.size() == 0) begin
                    report_mismatch("unexpected segment, duration", seg_if.duration, 0);
                end else begin
                    want = segs_due.pop_front();
                    if (seg_if.key_down !== want.key_down)
                        report_mismatch("key_down", seg_if.key_down, want.key_down);
                    if (seg_if.lamp_select !== want.lamp_select)
                        report_mismatch("lamp_select", seg_if.lamp_select, want.lamp_select);
                    if (seg_if.duration !== want.duration)
                        report_mismatch("duration", seg_if.duration, want.duration);
                    if (seg_if.last !== want.last)
                        report_mismatch("last", seg_if.last, want.last);
                end
            end
            seg_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (chr_if.valid && chr_if.ready) || (seg_if.valid && seg_if.ready)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        chr_if.valid     = 1'b0;
        chr_if.character = '0;
        seg_if.ready     = 1'b0;
        src_idle_pct     = 23;
        sink_idle_pct    = 59;
        regs.dot         = 31'd2666666;
        regs.dash        = 31'd10666664;
        regs.elem_gap    = 31'd3466665;
        regs.char_gap    = 31'd13866663;
        regs.word_gap    = 31'd41599989;
        regs.lamp        = 2'd3;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                configure(phase);
            end
            if (phase < 2) begin
                src_idle_pct  = 23;
                sink_idle_pct = 59;
            end else if (phase < 4) begin
                src_idle_pct  = 59;
                sink_idle_pct = 23;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            @(negedge i_clk);
            if (phase == 0) begin
                // shortest and longest patterns, all-dot, all-dash, hyphen, space, unknowns
                for (int k = 0; k < directed_a.len(); k++)
                    chars_to_send.push_back(directed_a[k]);
                chars_to_send.push_back(mck_pkg::CHAR_SPACE);
                chars_to_send.push_back(8'h00);
                chars_to_send.push_back(8'hFF);
                chars_to_send.push_back(8'h7F);
                chars_to_send.push_back(8'h80);
                chars_to_send.push_back("a");
                chars_to_send.push_back("z");
                chars_to_send.push_back(mck_pkg::CHAR_SPACE);
                for (int k = 0; k < directed_b.len(); k++)
                    chars_to_send.push_back(directed_b[k]);
            end
            repeat ((phase == 0) ? 15 : 37) chars_to_send.push_back(random_character());
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/mck_pkg.sv
design/mck_char_if.sv
design/mck_seg_if.sv
design/mck_front.sv
design/mck_queue.sv
design/mck_back.sv
design/morse_character_keyer_unit.sv
dv/morse_character_keyer_unit_tb.sv
